### sv/assert_macros.svh
// Assertion macros shared by the RTL modules.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/pbrle_pkg.sv
// Types, character constants and the base64 lookup for the pitch-bend decoder.
// No dependencies.
package pbrle_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned REPEAT_W = 16;
	localparam logic [REPEAT_W-1:0] REPEAT_MAX = '1;

	localparam logic [7:0] HASH_CHAR  = 8'h23;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;
	localparam logic [7:0] DIGIT_LO   = 8'h30;
	localparam logic [7:0] DIGIT_HI   = 8'h39;
	localparam logic [7:0] UPPER_LO   = 8'h41;
	localparam logic [7:0] UPPER_HI   = 8'h5A;
	localparam logic [7:0] LOWER_LO   = 8'h61;
	localparam logic [7:0] LOWER_HI   = 8'h7A;

	localparam logic [7:0] BAD_CODE    = 8'd255;
	localparam logic [7:0] PLUS_CODE   = 8'd62;
	localparam logic [7:0] SLASH_CODE  = 8'd63;
	localparam logic [7:0] LOWER_BASE  = 8'd26;
	localparam logic [7:0] DIGIT_BASE  = 8'd52;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_RUN    = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       start_req;
	} item_t;

	typedef struct packed {
		logic                       emit;
		logic signed [SAMPLE_W-1:0] sample;
		logic [REPEAT_W-1:0]        repeat_res;
	} result_t;

	function automatic logic [7:0] b64_code(input logic [7:0] c);
		logic [7:0] code;
		if (c inside {[UPPER_LO:UPPER_HI]})
			code = c - UPPER_LO;
		else if (c inside {[LOWER_LO:LOWER_HI]})
			code = c - LOWER_LO + LOWER_BASE;
		else if (c inside {[DIGIT_LO:DIGIT_HI]})
			code = c - DIGIT_LO + DIGIT_BASE;
		else if (c == PLUS_CHAR)
			code = PLUS_CODE;
		else if (c == SLASH_CHAR)
			code = SLASH_CODE;
		else
			code = BAD_CODE;
		return code;
	endfunction

endpackage

### sv/pbrle_if.sv
// Valid/ready channel interfaces for the pitch-bend decoder: characters in, samples out.
// No dependencies.
interface pbrle_chr_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       start_req;

	modport source (output valid, output symbol, output start_req, input ready);
	modport sink (input valid, input symbol, input start_req, output ready);
endinterface

interface pbrle_res_if;
	logic               valid;
	logic               ready;
	logic signed [11:0] sample;
	logic [15:0]        repeat_res;

	modport source (output valid, output sample, output repeat_res, input ready);
	modport sink (input valid, input sample, input repeat_res, output ready);
endinterface

### sv/pbrle_core.sv
// Parser state and per-character decode: pair assembly and run-length count.
// Depends on pbrle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pbrle_core #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  pbrle_pkg::item_t  item,
	output pbrle_pkg::result_t res
);

	localparam int unsigned CW = COUNT_WIDTH;
	localparam int unsigned PW = CW + 4;
	localparam int unsigned NW = (CW > pbrle_pkg::REPEAT_W) ? CW : pbrle_pkg::REPEAT_W;

	pbrle_pkg::phase_t ph_q, ph_e, ph_n;
	logic [7:0]  first_q, first_e, first_n;
	logic [CW-1:0] rc_q, rc_e, rc_n;
	logic [pbrle_pkg::SAMPLE_W-1:0] last_q, last_e, last_n;
	logic have_q, have_e, have_n;

	logic [7:0]  code;
	logic [pbrle_pkg::SAMPLE_W-1:0] pair_val;
	logic [PW-1:0] prod;
	logic [NW-1:0] n_w;
	logic is_hash, is_digit;

	// a string start sees the reset state before the character is applied
	always_comb begin
		ph_e    = item.start_req ? pbrle_pkg::PH_FIRST : ph_q;
		first_e = item.start_req ? 8'd0 : first_q;
		rc_e    = item.start_req ? '0 : rc_q;
		last_e  = item.start_req ? '0 : last_q;
		have_e  = item.start_req ? 1'b0 : have_q;
	end

	always_comb begin
		code     = pbrle_pkg::b64_code(item.symbol);
		pair_val = {first_e[5:0], 6'b000000} + {4'b0000, code};
		is_hash  = (item.symbol == pbrle_pkg::HASH_CHAR);
		is_digit = item.symbol inside {[pbrle_pkg::DIGIT_LO:pbrle_pkg::DIGIT_HI]};
		// count * 10 + digit, as two shifts and adds
		prod = PW'({rc_e, 3'b000}) + PW'({rc_e, 1'b0})
			+ PW'(4'(item.symbol - pbrle_pkg::DIGIT_LO));
		n_w  = NW'(rc_e) - NW'(1);
	end

	always_comb begin
		ph_n    = ph_e;
		first_n = first_e;
		rc_n    = rc_e;
		last_n  = last_e;
		have_n  = have_e;
		res.emit       = 1'b0;
		res.sample     = last_e;
		res.repeat_res = pbrle_pkg::REPEAT_W'(1);
		case (ph_e)
			pbrle_pkg::PH_SECOND: begin
				res.emit   = 1'b1;
				res.sample = pair_val;
				last_n     = pair_val;
				have_n     = 1'b1;
				ph_n       = pbrle_pkg::PH_FIRST;
			end
			pbrle_pkg::PH_RUN: begin
				if (is_hash) begin
					ph_n = pbrle_pkg::PH_FIRST;
					if (have_e && rc_e >= CW'(2)) begin
						res.emit       = 1'b1;
						res.repeat_res = (n_w > NW'(pbrle_pkg::REPEAT_MAX)) ?
							pbrle_pkg::REPEAT_MAX : n_w[pbrle_pkg::REPEAT_W-1:0];
					end
				end else if (is_digit) begin
					rc_n = (|prod[PW-1:CW]) ? '1 : prod[CW-1:0];
				end
			end
			default: begin
				if (is_hash) begin
					ph_n = pbrle_pkg::PH_RUN;
					rc_n = '0;
				end else begin
					first_n = code;
					ph_n    = pbrle_pkg::PH_SECOND;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= pbrle_pkg::PH_FIRST;
			first_q <= '0;
			rc_q    <= '0;
			last_q  <= '0;
			have_q  <= 1'b0;
		end else if (step) begin
			ph_q    <= ph_n;
			first_q <= first_n;
			rc_q    <= rc_n;
			last_q  <= last_n;
			have_q  <= have_n;
		end
	end

	// a run can only repeat a value that exists
	`ASSERT_IMPLIES(a_run_needs_last, clk, arst_n,
		res.emit && ph_e == pbrle_pkg::PH_RUN, have_e)
	// a pair always reports a single occurrence
	`ASSERT_IMPLIES(a_pair_count_one, clk, arst_n,
		res.emit && ph_e == pbrle_pkg::PH_SECOND, res.repeat_res == pbrle_pkg::REPEAT_W'(1))

endmodule

### sv/pitchbend_base64_rle_decoder.sv
// Top level of the pitch-bend base64 run-length decoder: input stage and result register.
// Depends on pbrle_pkg, pbrle_if, pbrle_core and assert_macros.svh.
//
// Usage:
//   chr carries one character byte per transfer; start_req set on the first
//   character of a string clears the parser before that character is used.
//   res carries decoded samples with a repeat count: a base64 pair gives one
//   sample with count 1, a run mark '#'digits'#' repeats the last sample.
//   Runs are reported as a count, never expanded.
// Timing:
//   A character is registered in the input stage on its transfer and decoded
//   from there; its result, if any, is loaded into the result register when it
//   advances and then offered on res. One character per cycle is sustained while
//   res is ready; the single decode stage between the two registers sets it.
// Reset:
//   arst_n clears both stages and the parser (no previous sample, pair phase).
// Stall:
//   While res is held, the result register keeps its contents; one more
//   character is taken into the input stage if it is empty, then chr.ready drops.
`include "assert_macros.svh"

module pitchbend_base64_rle_decoder #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	pbrle_chr_if.sink  chr,
	pbrle_res_if.source res
);

	logic               valid_s1;
	pbrle_pkg::item_t   item_s1;
	pbrle_pkg::result_t core_res;
	logic               advance;
	logic               out_valid_q;
	logic signed [pbrle_pkg::SAMPLE_W-1:0] sample_q;
	logic [pbrle_pkg::REPEAT_W-1:0]        repeat_q;

	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign chr.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (chr.ready)
			valid_s1 <= chr.valid;
	end

	always_ff @(posedge clk) begin
		if (chr.valid && chr.ready) begin
			item_s1.symbol    <= chr.symbol;
			item_s1.start_req <= chr.start_req;
		end
	end

	pbrle_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && core_res.emit)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && core_res.emit) begin
			sample_q <= core_res.sample;
			repeat_q <= core_res.repeat_res;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.sample     = sample_q;
	assign res.repeat_res = repeat_q;

	// every decoded result lands in the output register
	`ASSERT_NEXT(a_result_loaded, clk, arst_n, advance && core_res.emit, out_valid_q)
	// a repeat count of zero is never offered
	`ASSERT_ALWAYS(a_repeat_nonzero, clk, arst_n, !out_valid_q || repeat_q != '0)
	// a blocked character stays in the input stage untouched
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance,
		valid_s1 && item_s1 == $past(item_s1))

endmodule

### test/tb_pitchbend_base64_rle_decoder.sv
`timescale 1ns / 1ps
// Testbench for pitchbend_base64_rle_decoder: directed and random character streams
// with a pair/run decoder tracker. Depends on pbrle_pkg, pbrle_if and the RTL.

module tb_pitchbend_base64_rle_decoder;

	localparam int unsigned COUNT_W = 16;
	localparam longint RUN_MAX = (longint'(1) << COUNT_W) - 1;

	typedef struct {
		logic [pbrle_pkg::SAMPLE_W-1:0] sample;
		logic [pbrle_pkg::REPEAT_W-1:0] count;
	} bend_expect_t;

	// Tracks decoder state per accepted character and holds the samples still owed.
	class bend_tracker;
		pbrle_pkg::phase_t              phase;
		logic [7:0]                     first_code;
		longint                         run_count;
		logic [pbrle_pkg::SAMPLE_W-1:0] last_sample;
		bit                             have_last;
		bend_expect_t                   owed_samples[$];
		int                             errors;
		int                             chars_taken;

		function new();
			errors = 0;
			chars_taken = 0;
			clear();
		endfunction

		function void clear();
			phase = pbrle_pkg::PH_FIRST;
			first_code = '0;
			run_count = 0;
			last_sample = '0;
			have_last = 0;
		endfunction

		function logic [7:0] char_code(logic [7:0] c);
			case (c) inside
				[pbrle_pkg::UPPER_LO:pbrle_pkg::UPPER_HI]:
					return c - pbrle_pkg::UPPER_LO;
				[pbrle_pkg::LOWER_LO:pbrle_pkg::LOWER_HI]:
					return pbrle_pkg::LOWER_BASE + (c - pbrle_pkg::LOWER_LO);
				[pbrle_pkg::DIGIT_LO:pbrle_pkg::DIGIT_HI]:
					return pbrle_pkg::DIGIT_BASE + (c - pbrle_pkg::DIGIT_LO);
				pbrle_pkg::PLUS_CHAR:  return pbrle_pkg::PLUS_CODE;
				pbrle_pkg::SLASH_CHAR: return pbrle_pkg::SLASH_CODE;
				default:               return pbrle_pkg::BAD_CODE;
			endcase
		endfunction

		function void owe(logic [pbrle_pkg::SAMPLE_W-1:0] s,
			logic [pbrle_pkg::REPEAT_W-1:0] n);
			bend_expect_t e;
			e.sample = s;
			e.count = n;
			owed_samples.insert(owed_samples.size(), e);
		endfunction

		function void take_char(logic [7:0] sym, logic restart);
			logic [7:0]  code;
			logic [13:0] sum;
			longint      n;
			chars_taken++;
			if (restart)
				clear();
			code = char_code(sym);
			case (phase)
				pbrle_pkg::PH_SECOND: begin
					sum = {first_code, 6'b0} + {6'b0, code};
					last_sample = sum[pbrle_pkg::SAMPLE_W-1:0];
					have_last = 1;
					phase = pbrle_pkg::PH_FIRST;
					owe(last_sample, pbrle_pkg::REPEAT_W'(1));
				end
				pbrle_pkg::PH_RUN: begin
					if (sym == pbrle_pkg::HASH_CHAR) begin
						phase = pbrle_pkg::PH_FIRST;
						if (have_last && run_count >= 2) begin
							n = run_count - 1;
							if (n > longint'(pbrle_pkg::REPEAT_MAX))
								n = longint'(pbrle_pkg::REPEAT_MAX);
							owe(last_sample, n[pbrle_pkg::REPEAT_W-1:0]);
						end
					end else if (sym >= pbrle_pkg::DIGIT_LO && sym <= pbrle_pkg::DIGIT_HI) begin
						n = run_count * 10 + longint'(sym - pbrle_pkg::DIGIT_LO);
						run_count = (n > RUN_MAX) ? RUN_MAX : n;
					end
				end
				default: begin
					if (sym == pbrle_pkg::HASH_CHAR) begin
						phase = pbrle_pkg::PH_RUN;
						run_count = 0;
					end else begin
						first_code = code;
						phase = pbrle_pkg::PH_SECOND;
					end
				end
			endcase
		endfunction

		function void match_sample(logic [pbrle_pkg::SAMPLE_W-1:0] s,
			logic [pbrle_pkg::REPEAT_W-1:0] n);
			bend_expect_t e;
			if (owed_samples.size() == 0) begin
				errors++;
				$display("%0t: unexpected sample %0d count %0d", $time, $signed(s), n);
				return;
			end
			e = owed_samples.pop_front();
			if (s !== e.sample) begin
				errors++;
				$display("%0t: sample expected %0d actual %0d", $time,
					$signed(e.sample), $signed(s));
			end
			if (n !== e.count) begin
				errors++;
				$display("%0t: repeat_res expected %0d actual %0d", $time, e.count, n);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	pbrle_chr_if chr_bus();
	pbrle_res_if res_bus();

	bend_tracker tracker;
	bit no_idle;
	bit held_long;
	int chars_sent;

	pitchbend_base64_rle_decoder #(.COUNT_WIDTH(COUNT_W)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.chr(chr_bus),
		.res(res_bus)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] b64_char();
		int i;
		i = $urandom_range(0, 63);
		if (i < 26) return 8'(pbrle_pkg::UPPER_LO + i);
		if (i < 52) return 8'(pbrle_pkg::LOWER_LO + (i - 26));
		if (i < 62) return 8'(pbrle_pkg::DIGIT_LO + (i - 52));
		if (i == 62) return pbrle_pkg::PLUS_CHAR;
		return pbrle_pkg::SLASH_CHAR;
	endfunction

	task automatic send_char(input logic [7:0] sym, input logic restart = 1'b0);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			chr_bus.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		chr_bus.valid <= 1;
		chr_bus.symbol <= sym;
		chr_bus.start_req <= restart;
		do @(posedge clk); while (!chr_bus.ready);
		chars_sent++;
	endtask

	task automatic send_run(input int digits, input bit noisy, input bit closed);
		logic [7:0] junk;
		send_char(pbrle_pkg::HASH_CHAR);
		for (int i = 0; i < digits; i++) begin
			if (noisy && $urandom_range(0, 3) == 0) begin
				junk = 8'($urandom_range(0, 255));
				send_char((junk == pbrle_pkg::HASH_CHAR) ? 8'h00 : junk);
			end
			send_char(8'(pbrle_pkg::DIGIT_LO + $urandom_range(0, 9)));
		end
		if (closed)
			send_char(pbrle_pkg::HASH_CHAR);
	endtask

	// transfer monitor: inputs first, so an expectation exists before its sample
	always @(posedge clk) begin
		if (arst_n) begin
			if (chr_bus.valid && chr_bus.ready)
				tracker.take_char(chr_bus.symbol, chr_bus.start_req);
			if (res_bus.valid && res_bus.ready)
				tracker.match_sample(res_bus.sample, res_bus.repeat_res);
		end
	end

	// sink side; one long hold-off partway through so the input side backs up
	initial begin
		int n;
		res_bus.ready <= 0;
		held_long = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held_long && tracker.chars_taken >= 300) begin
				held_long = 1;
				res_bus.ready <= 0;
				repeat (300) @(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					res_bus.ready <= 0;
					repeat (n) @(posedge clk);
				end
			end
			res_bus.ready <= 1;
		end
	end

	initial begin
		int r;
		bit restart;
		tracker = new();
		no_idle = 0;
		chars_sent = 0;
		arst_n <= 0;
		chr_bus.valid <= 0;
		chr_bus.symbol <= '0;
		chr_bus.start_req <= 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// run before any sample: nothing
		send_char(pbrle_pkg::HASH_CHAR, 1);
		send_char("5");
		send_char(pbrle_pkg::HASH_CHAR);
		// largest and smallest sample
		send_char("f");
		send_char(pbrle_pkg::SLASH_CHAR);
		send_char("g");
		send_char("A");
		// empty run, then a run of one: both silent
		send_char(pbrle_pkg::HASH_CHAR);
		send_char(pbrle_pkg::HASH_CHAR);
		send_char(pbrle_pkg::HASH_CHAR);
		send_char("1");
		send_char(pbrle_pkg::HASH_CHAR);
		// count saturates, stray byte inside the run is skipped
		send_char(pbrle_pkg::HASH_CHAR);
		send_char("9");
		send_char(8'hFF);
		send_char("9");
		send_char("9");
		send_char("9");
		send_char("9");
		send_char(pbrle_pkg::HASH_CHAR);
		// invalid bytes in a pair
		send_char(8'h00);
		send_char(8'hFF);
		// restart mid-pair, then '#' as second character of a pair
		send_char("Q");
		send_char(pbrle_pkg::PLUS_CHAR, 1);
		send_char(pbrle_pkg::HASH_CHAR);

		restart = 0;
		while (chars_sent < 950) begin
			if ($urandom_range(0, 99) < 3)
				no_idle = ~no_idle;
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_char(b64_char(), restart);
				send_char(b64_char());
				restart = 0;
			end else if (r < 75) begin
				if (restart)
					send_char(b64_char(), 1);
				restart = 0;
				if ($urandom_range(0, 9) == 0)
					send_run($urandom_range(6, 8), 0, 1);
				else
					send_run($urandom_range(0, 4), $urandom_range(0, 3) == 0, 1);
			end else if (r < 85) begin
				send_char(8'($urandom_range(0, 255)), restart);
				restart = 0;
			end else if (r < 92) begin
				if (restart)
					send_char(b64_char(), 1);
				restart = 0;
				send_run($urandom_range(0, 3), 1, 0);
			end else begin
				restart = 1;
			end
		end
		chr_bus.valid <= 0;

		while (tracker.owed_samples.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.owed_samples.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
